FILE: src/mtvb_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the morph target vertex blend
// no dependencies

package mtvb_pkg;

  typedef enum logic [1:0] {
    KIND_POS     = 2'd0,
    KIND_NORMAL  = 2'd1,
    KIND_TANGENT = 2'd2,
    KIND_UV      = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic               sign_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               out_sign;
    logic               degenerate;
  } out_t;

  // control and data that ride along with an item through the back half
  typedef struct packed {
    logic [2:0][31:0] r;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic             renorm;
    logic             zero;
    logic             uv;
    logic             sgn;
  } side_t;

  localparam int WEIGHT_W  = 17;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  localparam int LERP_ST  = 3;
  localparam int SCALE_ST = 5;
  localparam int SQRT_ST  = 32;
  localparam int QUOT_W   = 17;
  localparam int DIV_ST   = QUOT_W + 1;
  localparam int LATENCY  = LERP_ST + SCALE_ST + SQRT_ST + DIV_ST + 1;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] res;
    if (v > 36'sh07FFFFFFF) begin
      res = 32'h7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      res = 32'h80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

FILE: src/mtvb_lerp.sv
`timescale 1ns / 1ps
// blend front end: difference, weight multiply, round and saturate
// depends on mtvb_pkg

module mtvb_lerp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  mtvb_pkg::in_t                    in_item,
  input  logic [mtvb_pkg::WEIGHT_W-1:0]    weight,
  output logic                             out_valid,
  output mtvb_pkg::side_t                  out_side
);

  logic                              v1_r, v2_r, v3_r;
  logic [31:0]                       a1_r [3];
  logic [31:0]                       a2_r [3];
  logic signed [32:0]                d1_r [3];
  logic signed [50:0]                p2_r [3];
  logic [mtvb_pkg::WEIGHT_W-1:0]     w1_r;
  logic                              wz1_r, wz2_r;
  logic [1:0]                        kind1_r, kind2_r;
  logic                              sgn1_r, sgn2_r;
  mtvb_pkg::side_t                   side3_r, side3_nxt;
  logic [31:0]                       a_in [3];
  logic [31:0]                       b_in [3];

  assign a_in[0] = in_item.a_x;
  assign a_in[1] = in_item.a_y;
  assign a_in[2] = in_item.a_z;
  assign b_in[0] = in_item.b_x;
  assign b_in[1] = in_item.b_y;
  assign b_in[2] = in_item.b_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a1_r[i] <= a_in[i];
      d1_r[i] <= $signed({b_in[i][31], b_in[i]}) - $signed({a_in[i][31], a_in[i]});
      a2_r[i] <= a1_r[i];
      p2_r[i] <= 51'(d1_r[i] * $signed({1'b0, w1_r}));
    end
    w1_r    <= weight;
    wz1_r   <= (weight == '0);
    kind1_r <= in_item.operation;
    sgn1_r  <= in_item.sign_in;
    wz2_r   <= wz1_r;
    kind2_r <= kind1_r;
    sgn2_r  <= sgn1_r;
    side3_r <= side3_nxt;
  end

  always_comb begin
    logic signed [50:0] t;
    logic signed [35:0] s;
    side3_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      // floor shift after adding half for round to nearest
      t = p2_r[i] + 51'sd32768;
      s = $signed({{4{a2_r[i][31]}}, a2_r[i]}) + $signed({t[50], t[50:16]});
      side3_nxt.r[i] = wz2_r ? a2_r[i] : mtvb_pkg::sat32(s);
    end
    side3_nxt.renorm = !wz2_r && (kind2_r == mtvb_pkg::KIND_NORMAL ||
                                  kind2_r == mtvb_pkg::KIND_TANGENT);
    side3_nxt.uv  = (kind2_r == mtvb_pkg::KIND_UV);
    side3_nxt.sgn = sgn2_r;
  end

  assign out_valid = v3_r;
  assign out_side  = side3_r;

endmodule

FILE: src/mtvb_scale.sv
`timescale 1ns / 1ps
// magnitudes, scale-up shift and sum of squares ahead of the square root
// depends on mtvb_pkg

module mtvb_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mtvb_pkg::side_t in_side,
  output logic            out_valid,
  output logic [63:0]     out_sum,
  output mtvb_pkg::side_t out_side
);

  logic [mtvb_pkg::SCALE_ST-1:0] vld_r;
  mtvb_pkg::side_t s1_r, s2_r, s3_r, s4_r, s5_r;
  mtvb_pkg::side_t s1_nxt, s3_nxt;
  logic [31:0] max1_r, max1_nxt;
  logic [4:0]  sh2_r;
  logic [63:0] sq4_r [3];
  logic [63:0] sum5_r;

  function automatic logic [4:0] shift_amt(input logic [31:0] m);
    logic [4:0] s;
    s = '0;
    for (int i = 0; i < 30; i++) begin
      if (m[i]) s = 5'(30 - i);
    end
    if (m[31] || m[30]) s = '0;
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[mtvb_pkg::SCALE_ST-2:0], in_valid};
    end
  end

  always_comb begin
    s1_nxt   = in_side;
    max1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.neg[i] = in_side.r[i][31];
      s1_nxt.mag[i] = in_side.r[i][31] ? (~in_side.r[i] + 32'd1) : in_side.r[i];
      if (s1_nxt.mag[i] > max1_nxt) max1_nxt = s1_nxt.mag[i];
    end
    s1_nxt.zero = (max1_nxt == '0);
  end

  always_comb begin
    s3_nxt = s2_r;
    for (int i = 0; i < 3; i++) begin
      s3_nxt.mag[i] = s2_r.mag[i] << sh2_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= s1_nxt;
    max1_r <= max1_nxt;
    s2_r   <= s1_r;
    sh2_r  <= shift_amt(max1_r);
    s3_r   <= s3_nxt;
    s4_r   <= s3_r;
    for (int i = 0; i < 3; i++) begin
      sq4_r[i] <= s3_r.mag[i] * s3_r.mag[i];
    end
    s5_r   <= s4_r;
    sum5_r <= sq4_r[0] + sq4_r[1] + sq4_r[2];
  end

  assign out_valid = vld_r[mtvb_pkg::SCALE_ST-1];
  assign out_sum   = sum5_r;
  assign out_side  = s5_r;

endmodule

FILE: src/mtvb_isqrt.sv
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage
// depends on mtvb_pkg

module mtvb_isqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [63:0]     in_sum,
  input  mtvb_pkg::side_t in_side,
  output logic            out_valid,
  output logic [31:0]     out_root,
  output mtvb_pkg::side_t out_side
);

  localparam int N = mtvb_pkg::SQRT_ST;

  logic            vld_r  [N];
  logic [63:0]     x_r    [N];
  logic [33:0]     rem_r  [N];
  logic [31:0]     root_r [N];
  mtvb_pkg::side_t side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam int I = N - 1 - k;
    logic            v_p;
    logic [63:0]     x_p;
    logic [33:0]     rem_p, rem_nxt;
    logic [31:0]     root_p, root_nxt;
    mtvb_pkg::side_t side_p;
    logic [35:0]     rem_sh, trial;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign x_p    = in_sum;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = in_side;
    end else begin : g_next
      assign v_p    = vld_r[k-1];
      assign x_p    = x_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign side_p = side_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_p, x_p[2*I+1 -: 2]};
      trial  = {2'b00, root_p, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = 34'(rem_sh - trial);
        root_nxt = {root_p[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[33:0];
        root_nxt = {root_p[30:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      x_r[k]    <= x_p;
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      side_r[k] <= side_p;
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

FILE: src/mtvb_div.sv
`timescale 1ns / 1ps
// pipelined rounded divide of each magnitude by the length, one quotient bit per stage
// depends on mtvb_pkg

module mtvb_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [31:0]                      in_len,
  input  mtvb_pkg::side_t                  in_side,
  output logic                             out_valid,
  output logic [2:0][mtvb_pkg::QUOT_W-1:0] out_quot,
  output mtvb_pkg::side_t                  out_side
);

  localparam int Q = mtvb_pkg::QUOT_W;

  logic            vld_r  [Q+1];
  logic [31:0]     len_r  [Q+1];
  mtvb_pkg::side_t side_r [Q+1];
  logic [31:0]     rem_r  [Q+1][3];
  logic [Q-1:0]    lo_r   [Q+1][3];
  logic [Q-1:0]    q_r    [Q+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  // numerator is mag * 65536 + len / 2; its top bits are already below len
  always_ff @(posedge clk) begin
    logic [47:0] num;
    len_r[0]  <= in_len;
    side_r[0] <= in_side;
    for (int i = 0; i < 3; i++) begin
      num         = {in_side.mag[i], 16'h0000} + {17'h00000, in_len[31:1]};
      rem_r[0][i] <= {1'b0, num[47:Q]};
      lo_r[0][i]  <= num[Q-1:0];
      q_r[0][i]   <= '0;
    end
  end

  for (genvar k = 1; k <= Q; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      logic [32:0] rs;
      logic        ge;
      len_r[k]  <= len_r[k-1];
      side_r[k] <= side_r[k-1];
      for (int i = 0; i < 3; i++) begin
        rs = {rem_r[k-1][i], lo_r[k-1][i][Q-k]};
        ge = (rs >= {1'b0, len_r[k-1]});
        rem_r[k][i] <= ge ? 32'(rs - {1'b0, len_r[k-1]}) : rs[31:0];
        lo_r[k][i]  <= lo_r[k-1][i];
        q_r[k][i]   <= {q_r[k-1][i][Q-2:0], ge};
      end
    end
  end

  assign out_valid = vld_r[Q];
  assign out_side  = side_r[Q];
  for (genvar i = 0; i < 3; i++) begin : g_out
    assign out_quot[i] = q_r[Q][i];
  end

endmodule

FILE: src/morph_target_vertex_blend.sv
`timescale 1ns / 1ps
// top level of the morph target vertex blend: weight register, pipeline and result register
// depends on mtvb_pkg, mtvb_lerp, mtvb_scale, mtvb_isqrt, mtvb_div

// Takes one vertex attribute beat per clock and never asserts busy. Every beat
// produces exactly one result, shown for one cycle with out_valid, after passing
// through 3 blend stages, 5 scaling stages, 32 square root stages (one root bit
// each), 18 divider stages (a setup stage, then one quotient bit each) and the
// output register. The receiver cannot stall. Write blend_weight only while no
// beat is in flight.

module morph_target_vertex_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mtvb_pkg::in_t                 in_item,
  output logic                          out_valid,
  output mtvb_pkg::out_t                out_item,
  input  logic                          cfg_we,
  input  logic [mtvb_pkg::WEIGHT_W-1:0] cfg_wdata
);

  logic [mtvb_pkg::WEIGHT_W-1:0] weight_r, weight_eff;
  logic                          lerp_v, scale_v, sqrt_v, div_v;
  mtvb_pkg::side_t               lerp_side, scale_side, sqrt_side, div_side;
  logic [63:0]                   sum;
  logic [31:0]                   root;
  logic [2:0][mtvb_pkg::QUOT_W-1:0] quot;
  logic                          out_valid_r;
  mtvb_pkg::out_t                out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else if (cfg_we) begin
      weight_r <= cfg_wdata;
    end
  end

  assign weight_eff = weight_r[mtvb_pkg::WEIGHT_W-1] ? mtvb_pkg::WEIGHT_ONE : weight_r;
  assign busy       = 1'b0;

  mtvb_lerp u_lerp (
    .clk, .rst_n,
    .in_valid (start && !busy),
    .in_item,
    .weight   (weight_eff),
    .out_valid(lerp_v),
    .out_side (lerp_side)
  );

  mtvb_scale u_scale (
    .clk, .rst_n,
    .in_valid (lerp_v),
    .in_side  (lerp_side),
    .out_valid(scale_v),
    .out_sum  (sum),
    .out_side (scale_side)
  );

  mtvb_isqrt u_isqrt (
    .clk, .rst_n,
    .in_valid (scale_v),
    .in_sum   (sum),
    .in_side  (scale_side),
    .out_valid(sqrt_v),
    .out_root (root),
    .out_side (sqrt_side)
  );

  mtvb_div u_div (
    .clk, .rst_n,
    .in_valid (sqrt_v),
    .in_len   (root),
    .in_side  (sqrt_side),
    .out_valid(div_v),
    .out_quot (quot),
    .out_side (div_side)
  );

  always_comb begin
    logic [31:0] comp [3];
    logic [31:0] qx;
    for (int i = 0; i < 3; i++) begin
      qx = {{(32 - mtvb_pkg::QUOT_W){1'b0}}, quot[i]};
      if (!div_side.renorm) begin
        comp[i] = div_side.r[i];
      end else if (div_side.zero) begin
        comp[i] = '0;
      end else begin
        comp[i] = div_side.neg[i] ? (~qx + 32'd1) : qx;
      end
    end
    out_nxt.out_x      = comp[0];
    out_nxt.out_y      = comp[1];
    out_nxt.out_z      = div_side.uv ? 32'd0 : comp[2];
    out_nxt.out_sign   = div_side.sgn;
    out_nxt.degenerate = div_side.renorm && div_side.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(mtvb_pkg::LATENCY) out_valid)
    else $error("result strobe missing after accepted beat");

  // no result strobe without a beat accepted the latency earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n, mtvb_pkg::LATENCY)) |->
      $past(start && !busy, mtvb_pkg::LATENCY))
    else $error("result strobe without an input beat");

  // a degenerate result carries the zero vector
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.degenerate) |->
      (out_item.out_x == 32'sd0 && out_item.out_y == 32'sd0 && out_item.out_z == 32'sd0))
    else $error("degenerate result with nonzero vector");

endmodule

FILE: bench/mtvb_blend_checker.sv
`timescale 1ns / 1ps
// checker for the morph target vertex blend: watches beats in and out, predicts and compares
// depends on mtvb_pkg

module mtvb_blend_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  mtvb_pkg::in_t  in_item,
  input  logic           out_valid,
  input  mtvb_pkg::out_t out_item,
  input  logic           cfg_we,
  input  logic [16:0]    cfg_wdata,
  output int             fail_count,
  output int             pending
);

  logic [16:0]     weight;
  mtvb_pkg::out_t  blend_q[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_q16(input longint t);
    if (t >= 0) return t / 65536;
    return -((-t + 65535) / 65536);
  endfunction

  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic mtvb_pkg::out_t predict_blend(input mtvb_pkg::in_t it,
                                                   input logic [16:0] wreg);
    mtvb_pkg::out_t o;
    longint a[3], b[3], r[3], w, s;
    longint unsigned m, sum, len, q, mg;
    logic degen;
    a[0] = it.a_x; a[1] = it.a_y; a[2] = it.a_z;
    b[0] = it.b_x; b[1] = it.b_y; b[2] = it.b_z;
    w = (wreg > 17'h10000) ? 65536 : longint'(wreg);
    degen = 1'b0;
    if (w == 0) begin
      for (int i = 0; i < 3; i++) r[i] = a[i];
    end else begin
      for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + floor_q16((b[i] - a[i]) * w + 32768));
      if (mtvb_pkg::kind_t'(it.operation) == mtvb_pkg::KIND_NORMAL ||
          mtvb_pkg::kind_t'(it.operation) == mtvb_pkg::KIND_TANGENT) begin
        m = 0;
        for (int i = 0; i < 3; i++) begin
          mg = r[i] < 0 ? -r[i] : r[i];
          if (mg > m) m = mg;
        end
        if (m == 0) begin
          degen = 1'b1;
        end else begin
          while (m < (64'd1 << 30)) begin
            m = m * 2;
            for (int i = 0; i < 3; i++) r[i] = r[i] * 2;
          end
          sum = 0;
          for (int i = 0; i < 3; i++) begin
            mg = r[i] < 0 ? -r[i] : r[i];
            sum += mg * mg;
          end
          len = root64(sum);
          for (int i = 0; i < 3; i++) begin
            mg = r[i] < 0 ? -r[i] : r[i];
            q = (mg * 65536 + len / 2) / len;
            s = (q > 64'h80000000) ? 64'h80000000 : q;
            r[i] = clamp32(r[i] < 0 ? -s : s);
          end
        end
      end
    end
    if (mtvb_pkg::kind_t'(it.operation) == mtvb_pkg::KIND_UV) r[2] = 0;
    o.out_x = r[0][31:0];
    o.out_y = r[1][31:0];
    o.out_z = r[2][31:0];
    o.out_sign = it.sign_in;
    o.degenerate = degen;
    return o;
  endfunction

  always @(posedge clk) begin
    mtvb_pkg::out_t exp_o;
    if (!rst_n) begin
      weight <= '0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) weight <= cfg_wdata;
      if (start && !busy) blend_q.push_back(predict_blend(in_item, weight));
      if (out_valid) begin
        if (blend_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          exp_o = blend_q.pop_front();
          if (exp_o.out_x !== out_item.out_x || exp_o.out_y !== out_item.out_y ||
              exp_o.out_z !== out_item.out_z || exp_o.out_sign !== out_item.out_sign ||
              exp_o.degenerate !== out_item.degenerate) begin
            $display("%0t: expected x=%h y=%h z=%h s=%b d=%b actual x=%h y=%h z=%h s=%b d=%b",
                     $time, exp_o.out_x, exp_o.out_y, exp_o.out_z, exp_o.out_sign,
                     exp_o.degenerate, out_item.out_x, out_item.out_y, out_item.out_z,
                     out_item.out_sign, out_item.degenerate);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= blend_q.size();
    end
  end
endmodule

FILE: bench/tb_morph_target_vertex_blend.sv
`timescale 1ns / 1ps
// testbench top for the morph target vertex blend: stimulus, weight phases and verdict
// depends on mtvb_pkg, morph_target_vertex_blend and mtvb_blend_checker

module tb_morph_target_vertex_blend;

  logic           clk, rst_n, start, busy, out_valid, cfg_we;
  logic [16:0]    cfg_wdata;
  mtvb_pkg::in_t  in_item;
  mtvb_pkg::out_t out_item;
  int             fail_count, pending;
  bit             calm;

  morph_target_vertex_blend u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  mtvb_blend_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("morph_target_vertex_blend: mismatch");
    $finish;
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3) << 16;
      3: return 32'(signed'($urandom_range(0, 400000)) - 200000);
      default: return $urandom();
    endcase
  endfunction

  // one beat; waits for acceptance, optional idle burst afterward
  task automatic send_beat(input mtvb_pkg::in_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      in_item <= '0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic set_weight(input logic [16:0] w);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (mtvb_pkg::LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic rand_beat();
    mtvb_pkg::in_t it;
    it.operation = 2'($urandom_range(0, 3));
    it.a_x = rand_comp(); it.a_y = rand_comp(); it.a_z = rand_comp();
    it.b_x = rand_comp(); it.b_y = rand_comp(); it.b_z = rand_comp();
    it.sign_in = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      it.b_x = it.a_x; it.b_y = it.a_y; it.b_z = it.a_z;
      if ($urandom_range(0, 1)) begin
        it.a_x = 0; it.a_y = 0; it.a_z = 0; it.b_x = 0; it.b_y = 0; it.b_z = 0;
      end
    end
    send_beat(it);
  endtask

  logic [16:0] weights[8] = '{17'd0, 17'h10000, 17'h1FFFF, 17'd1, 17'h8000, 17'h0FFFF,
                              17'h4000, 17'h10001};

  initial begin
    mtvb_pkg::in_t it;
    rst_n = 1'b0; start = 1'b0; in_item = '0; cfg_we = 1'b0; cfg_wdata = '0; calm = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: every kind, extremes, zero vectors, at weights zero, half and one
    for (int p = 0; p < 3; p++) begin
      set_weight(p == 0 ? 17'd0 : (p == 1 ? 17'h8000 : 17'h10000));
      for (int k = 0; k < 4; k++) begin
        it = '0;
        it.operation = 2'(k);
        send_beat(it);
        it.a_x = 32'h7FFFFFFF; it.a_y = 32'h80000000; it.a_z = 32'h00010000;
        it.b_x = 32'h80000000; it.b_y = 32'h7FFFFFFF; it.b_z = 32'hFFFFFFFF;
        it.sign_in = 1'b1;
        send_beat(it);
      end
    end
    for (int p = 0; p < 8; p++) begin
      set_weight(p < 7 ? weights[p] : 17'($urandom_range(1, 65535)));
      if (p == 7) calm = 1'b1;
      for (int n = 0; n < 92; n++) rand_beat();
    end
    start <= 1'b0;
    in_item <= '0;
    while (pending != 0) @(posedge clk);
    repeat (mtvb_pkg::LATENCY + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("morph_target_vertex_blend: match");
    end else begin
      $display("morph_target_vertex_blend: mismatch");
    end
    $finish;
  end
endmodule

FILE: filelist.f
src/mtvb_pkg.sv
src/mtvb_lerp.sv
src/mtvb_scale.sv
src/mtvb_isqrt.sv
src/mtvb_div.sv
src/morph_target_vertex_blend.sv
bench/mtvb_blend_checker.sv
bench/tb_morph_target_vertex_blend.sv
